// ===== rtl/core/slxp_pkg.sv =====
// Package for the framed packet parser: constants, parse phases and the
// records passed between the front end, the frame queue and the emitter.
// No dependencies.
package slxp_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = 6;
    localparam int POS_W   = 5;
    localparam int ADDR_W  = POS_W + 1;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } parse_phase_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_SHOW = 2'd2
    } emit_state_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } frame_cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

// ===== rtl/core/slxp_if.sv =====
// Channel interfaces of the packet parser: received bytes in, payload
// results out. Depends on nothing.
interface slxp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slxp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [4:0] byte_position;
    logic [5:0] frame_length;
    logic       last;

    modport source (output valid, output data_byte, output byte_position,
                    output frame_length, output last, input ready);
    modport sink (input valid, input data_byte, input byte_position,
                  input frame_length, input last, output ready);
endinterface

// ===== rtl/core/slxp_front.sv =====
// Front end of the packet parser: frame state machine, checksum and payload
// writes into the bank it owns. Depends on slxp_pkg and slxp_in_if.
module slxp_front (
    input  logic                clk,
    input  logic                rst_n,
    slxp_in_if.sink             in_ch,
    input  logic                q_full,
    output logic                push,
    output slxp_pkg::frame_cmd_t push_cmd,
    output slxp_pkg::mem_wr_t   mem_wr
);
    import slxp_pkg::*;

    parse_phase_t     phase_reg, phase_next;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic [LEN_W-1:0] rcv_reg, rcv_next;
    logic [7:0]       xor_reg, xor_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic [7:0]       b;
    logic             len_ok;
    logic             room;
    logic             sum_ok;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign b           = in_ch.rx_byte;
    assign len_ok      = b <= 8'(MAX_LEN);
    assign room        = rcv_reg < exp_reg;
    assign sum_ok      = xor_reg == b;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:   phase_next = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                PH_SYNC2:   phase_next = (b == SYNC_SECOND) ? PH_LEN : PH_SYNC1;
                PH_LEN:     phase_next = len_ok ? PH_PAYLOAD : PH_SYNC1;
                PH_PAYLOAD:
                begin
                    if (!room)
                        phase_next = PH_SYNC1;
                    else if (rcv_reg + 1'b1 == exp_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:   phase_next = PH_SYNC1;
                default:    phase_next = PH_SYNC1;
            endcase
        end
    end

    always_comb
    begin
        exp_next  = exp_reg;
        rcv_next  = rcv_reg;
        xor_next  = xor_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1, PH_SYNC2:
                begin
                end
                PH_LEN:
                begin
                    exp_next = len_ok ? b[LEN_W-1:0] : '0;
                    rcv_next = '0;
                    xor_next = '0;
                end
                PH_PAYLOAD:
                begin
                    if (room)
                    begin
                        rcv_next = rcv_reg + 1'b1;
                        xor_next = xor_reg ^ b;
                    end
                    else
                    begin
                        exp_next = '0;
                        rcv_next = '0;
                        xor_next = '0;
                    end
                end
                PH_CHECK:
                begin
                    exp_next = '0;
                    rcv_next = '0;
                    xor_next = '0;
                    if (sum_ok)
                        bank_next = !bank_reg;
                end
                default:
                begin
                    exp_next = '0;
                    rcv_next = '0;
                    xor_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        push          = accept && (phase_reg == PH_CHECK) && sum_ok;
        push_cmd.bank = bank_reg;
        push_cmd.len  = exp_reg;
        mem_wr.en     = accept && (phase_reg == PH_PAYLOAD) && room;
        mem_wr.addr   = {bank_reg, rcv_reg[POS_W-1:0]};
        mem_wr.data   = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            exp_reg   <= '0;
            rcv_reg   <= '0;
            xor_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            exp_reg   <= exp_next;
            rcv_reg   <= rcv_next;
            xor_reg   <= xor_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== rtl/core/slxp_queue.sv =====
// Two-entry queue of accepted frames between the front end and the emitter.
// Depends on slxp_pkg.
module slxp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  slxp_pkg::frame_cmd_t push_cmd,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output slxp_pkg::frame_cmd_t head
);
    import slxp_pkg::*;

    frame_cmd_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/slxp_back.sv =====
// Emitter of the packet parser: holds the two-bank payload memory and plays
// out the frame at the queue head. Depends on slxp_pkg and slxp_out_if.
module slxp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slxp_pkg::mem_wr_t    mem_wr,
    input  logic                 head_valid,
    input  slxp_pkg::frame_cmd_t head,
    output logic                 pop,
    slxp_out_if.source           out_ch
);
    import slxp_pkg::*;

    logic [7:0]       mem [2*MAX_LEN];
    logic [7:0]       rd_data_reg;
    emit_state_t      state_reg, state_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             rd_en;
    logic             is_last;

    assign is_last = ({1'b0, idx_reg} + 1'b1) == head.len;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (head_valid) state_next = B_READ;
            B_READ: state_next = B_SHOW;
            B_SHOW:
            begin
                if (out_ch.ready)
                    state_next = is_last ? B_IDLE : B_READ;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        rd_en    = state_reg == B_READ;
        pop      = (state_reg == B_SHOW) && out_ch.ready && is_last;
        idx_next = idx_reg;
        if (state_reg == B_IDLE)
            idx_next = '0;
        else if ((state_reg == B_SHOW) && out_ch.ready)
            idx_next = idx_reg + 1'b1;
        out_ch.valid         = state_reg == B_SHOW;
        out_ch.data_byte     = rd_data_reg;
        out_ch.byte_position = idx_reg;
        out_ch.frame_length  = head.len;
        out_ch.last          = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        if (rd_en)
            rd_data_reg <= mem[{head.bank, idx_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/core/sync_length_xor_packet_parser_top.sv =====
// Top level of the framed packet parser with XOR checksum.
// Depends on slxp_pkg, slxp_if, slxp_front, slxp_queue and slxp_back.
//
// The in_ch channel takes one received byte per transaction. Frames are
// 0xAA, 0x55, a length from 1 to 32, the payload and an XOR checksum over
// the payload. Bad sync, oversize lengths, zero lengths and bad checksums
// drop the frame with no output.
// The out_ch channel gives one transaction per payload byte of each good
// frame, with its position, the frame length and a last flag.
// The front end takes one byte per cycle while the queue is not full. A good
// frame is queued with its payload bank once its checksum byte is accepted;
// the emitter then reads each payload byte through the registered read of
// the payload memory and shows it, reading the next once out_ch is ready.
// Up to two good frames may wait; while both banks are held by frames not
// yet played out, in_ch.ready is low. A stalled receiver only holds the
// current result and fills the queue; the front end parses until it is full.
// Reset returns the parser to waiting for 0xAA and empties the queue;
// the payload memory is not cleared.
module sync_length_xor_packet_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    slxp_in_if.sink    in_ch,
    slxp_out_if.source out_ch
);
    import slxp_pkg::*;

    logic       push;
    logic       pop;
    logic       full;
    logic       head_valid;
    frame_cmd_t push_cmd;
    frame_cmd_t head;
    mem_wr_t    mem_wr;

    slxp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (full),
        .push     (push),
        .push_cmd (push_cmd),
        .mem_wr   (mem_wr)
    );

    slxp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    slxp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_wr     (mem_wr),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
